### sv/slt_pkg.sv
package slt_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int FIELD_W  = 11;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } slt_cmd_t;

endpackage

### sv/slt_cell.sv
module slt_cell
  import slt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  slt_cmd_t                 cmd,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic                     left_valid,
  input  logic                     left_ge,
  input  logic signed [DATA_W-1:0] right_val,
  input  logic                     right_valid,
  output logic signed [DATA_W-1:0] val_r,
  output logic                     valid_r,
  output logic                     ge_r,
  output logic                     eq_r
);

  logic signed [DATA_W-1:0] val_nxt;
  logic                     valid_nxt;
  logic                     ge_nxt;
  logic                     eq_nxt;

  always_comb begin
    ge_nxt    = ge_r;
    eq_nxt    = eq_r;
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (cmd.cmp) begin
      ge_nxt = !valid_r || (val_r >= key);
      eq_nxt = valid_r && (val_r == key);
    end
    // insert: cells at or past the slot move one place right
    if (cmd.ins && ge_r) begin
      val_nxt   = left_ge ? left_val : key;
      valid_nxt = valid_r | left_valid;
    end
    // delete: cells at or past the first match pull from the right
    if (cmd.del && ge_r) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ge_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ge_r    <= ge_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### sv/sorted_list_table_top.sv
// sorted table of up to CAPACITY signed 32-bit values in ascending order
// command channel: an item (in_op, in_value) is taken at a rising edge with
// start high and busy low; busy then stays high until the result is out
// ops: insert (ahead of equal values), delete first copy, find first copy
// result channel: out_valid is high for exactly one cycle with out_status,
// out_position and out_count; the receiver cannot stall it
// steps: in ST_CMP every cell compares its value with the key, in
// ST_APPLY the row of cells shifts and the first-match position is
// encoded; the result is registered at the end of ST_APPLY
// a new item is taken only once the previous one is done; start may be
// high again in the cycle where out_valid shows the previous result
// besides the shared key and command, every cell talks only to its two
// neighbors; the position comes from a one-hot boundary over the row
// reset (rst_n low at a rising edge) empties the table and drops any
// item in flight; the cell data themselves are not cleared
module sorted_list_table_top
  import slt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [FIELD_W-1:0]       out_position,
  output logic [FIELD_W-1:0]       out_count
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [OP_W-1:0]          op_r;
  logic signed [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_nxt;
  logic [STAT_W-1:0]        status_nxt;
  logic [FIELD_W-1:0]       position_nxt;

  slt_cmd_t                 cmd;
  logic signed [DATA_W-1:0] cell_val   [CAPACITY];
  logic                     cell_valid [CAPACITY];
  logic                     cell_ge    [CAPACITY];
  logic                     cell_eq    [CAPACITY];
  logic [CAPACITY-1:0]      bnd;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     full;

  assign busy = (state_r != ST_IDLE);
  assign full = (count_r >= CNT_W'(CAPACITY));

  // boundary: first cell that is empty or whose value is not below the key
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        bnd[i] = cell_ge[i];
      end else begin
        bnd[i] = cell_ge[i] && !cell_ge[i-1];
      end
      hit     = hit | (bnd[i] & cell_eq[i]);
      hit_idx = hit_idx | (bnd[i] ? IDX_W'(i) : '0);
    end
  end

  always_comb begin
    cmd.cmp = (state_r == ST_CMP);
    cmd.ins = (state_r == ST_APPLY) && (op_r == OP_INSERT) && !full;
    cmd.del = (state_r == ST_APPLY) && (op_r == OP_DELETE) && hit;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] l_val, r_val;
      logic                     l_valid, l_ge, r_valid;
      if (g == 0) begin : g_first
        assign l_val   = key_r;
        assign l_valid = 1'b1;
        assign l_ge    = 1'b0;
      end else begin : g_mid_l
        assign l_val   = cell_val[g-1];
        assign l_valid = cell_valid[g-1];
        assign l_ge    = cell_ge[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign r_val   = cell_val[g];
        assign r_valid = 1'b0;
      end else begin : g_mid_r
        assign r_val   = cell_val[g+1];
        assign r_valid = cell_valid[g+1];
      end
      slt_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key         (key_r),
        .left_val    (l_val),
        .left_valid  (l_valid),
        .left_ge     (l_ge),
        .right_val   (r_val),
        .right_valid (r_valid),
        .val_r       (cell_val[g]),
        .valid_r     (cell_valid[g]),
        .ge_r        (cell_ge[g]),
        .eq_r        (cell_eq[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STAT_OK;
    position_nxt  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        unique case (op_r)
          OP_INSERT: begin
            if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            if (hit) begin
              count_nxt = count_r - CNT_W'(1);
            end else begin
              status_nxt = STAT_NOT_FOUND;
            end
          end
          OP_FIND: begin
            if (hit) begin
              position_nxt = FIELD_W'(hit_idx) + FIELD_W'(1);
            end else begin
              status_nxt = STAT_NOT_FOUND;
            end
          end
          default: begin
            status_nxt = STAT_OK;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r  <= in_op;
      key_r <= in_value;
    end
    out_status   <= status_nxt;
    out_position <= position_nxt;
    out_count    <= FIELD_W'(count_nxt);
  end

`ifndef SYNTHESIS
  a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPLY |=> out_valid)
    else $error("no result after apply");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_count == FIELD_W'(CAPACITY))
    else $error("full reject with table not full");

  a_one_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPLY |-> $onehot0(bnd))
    else $error("more than one boundary cell");

  a_position_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_position != '0 |-> out_status == STAT_OK && out_position <= out_count)
    else $error("position without a match");
`endif

endmodule
